FILE: rtl/wmm_pkg.sv
// ----------------------------------------------------------------------------
// wmm_pkg: shared types and constants of the wildcard mask matcher
// Operation codes, mask symbols, case folding and the queue entry format.
// ----------------------------------------------------------------------------
package wmm_pkg;

    localparam int MASK_MAX = 32;
    localparam int ACT_W    = MASK_MAX + 1;
    localparam int LEN_W    = $clog2(MASK_MAX + 1);
    localparam int IDX_W    = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        OP_MASK_BYTE = 2'd0,
        OP_TEXT_BYTE = 2'd1,
        OP_END_TEXT  = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Upper-case one byte of the single-byte code page.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end else if (c >= 8'hE0) begin
            r = c - 8'h20;
        end else if (c == 8'hB8) begin
            r = 8'hA8;
        end
        return r;
    endfunction

endpackage

FILE: rtl/wmm_if.sv
// ----------------------------------------------------------------------------
// wmm_if: request and response channels of the wildcard mask matcher
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wmm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface wmm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic mask_overflow;

    modport source (output valid, output matched, output mask_overflow, input ready);
    modport sink   (input valid, input matched, input mask_overflow, output ready);
endinterface

FILE: rtl/wmm_front.sv
// ----------------------------------------------------------------------------
// wmm_front: request intake and command queue
// Folds the byte to upper case, classifies the request and queues it.
// ----------------------------------------------------------------------------
module wmm_front import wmm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wmm_req_if.sink       i_req,
    output t_q_head       o_head,
    input  logic          i_pop
);

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_push;

    assign i_req.ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;

    assign o_head = '{valid: (r_count != '0), cmd: r_q[r_rd_ptr]};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= '{op: t_op'(i_req.operation), data: fold_case(i_req.data_byte)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            unique case ({w_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");

endmodule

FILE: rtl/wmm_back.sv
// ----------------------------------------------------------------------------
// wmm_back: mask store and bit-parallel matcher
// Holds the mask, steps the active-position vector per text byte and
// registers the match result of each end of text.
// ----------------------------------------------------------------------------
module wmm_back import wmm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_head       i_head,
    output logic          o_pop,
    wmm_rsp_if.source     o_rsp
);

    logic [7:0]       r_mask [MASK_MAX];
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic [ACT_W-1:0] r_act;
    logic [ACT_W-1:0] r_start;
    logic             r_out_valid;
    logic             r_out_matched;
    logic             r_out_ovf;

    logic [MASK_MAX-1:0] w_in_len;
    logic [MASK_MAX-1:0] w_star;
    logic [ACT_W-1:0]    w_upto;
    logic [ACT_W-1:0]    w_raw;
    logic [ACT_W-1:0]    w_step;
    logic [ACT_W-1:0]    n_start;
    logic                w_full;
    logic                w_new_star;
    logic                w_hit;

    // Close a vector over stars: a set bit on a star sets the next bit.
    function automatic logic [ACT_W-1:0] star_close(input logic [ACT_W-1:0] act,
                                                    input logic [MASK_MAX-1:0] star);
        logic [ACT_W-1:0] g;
        logic [ACT_W-1:0] p;
        logic [ACT_W-1:0] g_n;
        logic [ACT_W-1:0] p_n;
        g = act;
        p = {star, 1'b0};
        for (int d = 1; d < ACT_W; d = d * 2) begin
            g_n = g;
            p_n = p;
            for (int i = 0; i < ACT_W; i++) begin
                if (i >= d) begin
                    g_n[i] = g[i] | (p[i] & g[i-d]);
                    p_n[i] = p[i] & p[i-d];
                end else begin
                    p_n[i] = 1'b0;
                end
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

    always_comb begin
        for (int i = 0; i < MASK_MAX; i++) begin
            w_in_len[i] = (LEN_W'(i) < r_len);
            w_star[i]   = w_in_len[i] && (r_mask[i] == SYM_STAR);
        end
        for (int i = 0; i < ACT_W; i++) begin
            w_upto[i] = (LEN_W'(i) <= r_len);
        end
    end

    // One text byte: stay on stars, advance on a matching literal or '?'.
    always_comb begin
        w_raw = '0;
        for (int i = 0; i < MASK_MAX; i++) begin
            if (r_act[i] && w_in_len[i]) begin
                if (w_star[i]) begin
                    w_raw[i] = 1'b1;
                end else if (r_mask[i] == SYM_ANY || r_mask[i] == i_head.cmd.data) begin
                    w_raw[i+1] = 1'b1;
                end
            end
        end
        w_step = star_close(w_raw, w_star);
    end

    // Extend the start closure when a star follows a run of leading stars.
    assign w_full     = (r_len == LEN_W'(MASK_MAX));
    assign w_new_star = (i_head.cmd.data == SYM_STAR) && r_start[r_len];
    assign n_start    = w_new_star ? (r_start | (ACT_W'(1) << (r_len + LEN_W'(1)))) : r_start;
    assign w_hit      = (r_len == '0) || r_act[r_len];

    assign o_pop = i_head.valid &&
                   (i_head.cmd.op != OP_END_TEXT || !r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.cmd.op == OP_MASK_BYTE && !w_full) begin
            r_mask[r_len[IDX_W-1:0]] <= i_head.cmd.data;
        end
        if (o_pop && i_head.cmd.op == OP_END_TEXT) begin
            r_out_matched <= w_hit;
            r_out_ovf     <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_act       <= ACT_W'(1);
            r_start     <= ACT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                unique case (i_head.cmd.op)
                    OP_MASK_BYTE: begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                            r_act <= r_start;
                        end else begin
                            r_len   <= r_len + LEN_W'(1);
                            r_start <= n_start;
                            r_act   <= n_start;
                        end
                    end
                    OP_TEXT_BYTE: begin
                        r_act <= w_step;
                    end
                    OP_END_TEXT: begin
                        r_act <= r_start;
                    end
                    OP_CLEAR: begin
                        r_len   <= '0;
                        r_ovf   <= 1'b0;
                        r_start <= ACT_W'(1);
                        r_act   <= ACT_W'(1);
                    end
                endcase
            end
            if (o_pop && i_head.cmd.op == OP_END_TEXT) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.matched       = r_out_matched;
    assign o_rsp.mask_overflow = r_out_ovf;

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.cmd.op == OP_END_TEXT) |=> r_out_valid)
        else $error("end of text did not load the result register");

    a_act_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act & ~w_upto) == '0 && (r_start & ~w_upto) == '0)
        else $error("active position beyond mask length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MASK_MAX))
        else $error("mask length beyond capacity");

endmodule

FILE: rtl/wildcard_mask_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_mask_matcher: case-insensitive '*' / '?' mask match of a text
// An end-of-text request is registered in the command queue and its verdict
// then in the result register, whose valid flag marks the result.
// Throughput: one request per cycle unless the 4-entry command queue is
// full; the match vector of all mask positions is updated per text byte.
// An end of text waits in the queue while an untaken result is still held.
// Reset clears the mask length, overflow flag, queue and result valid flag;
// mask store contents stay undefined and are never read before written.
// ----------------------------------------------------------------------------
module wildcard_mask_matcher import wmm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wmm_req_if.sink   i_req,
    wmm_rsp_if.source o_rsp
);

    t_q_head w_head;
    logic    w_pop;

    wmm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    wmm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the wildcard mask matcher
// Streams mask, text, end-of-text and clear requests through the request
// channel and predicts every match verdict with a bit-parallel matcher of
// its own. Directed cases come first, then random mask/text sequences under
// changing idle patterns, receiver hold-offs and full drains.
// ----------------------------------------------------------------------------
module testbench;
    import wmm_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 530;

    typedef struct packed {
        logic matched;
        logic mask_overflow;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    wmm_req_if req_ch();
    wmm_rsp_if rsp_ch();

    wildcard_mask_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Matcher prediction state
    logic [7:0]       mask_bytes [MASK_MAX];
    int               mask_len;
    logic [ACT_W-1:0] live_pos;
    logic             overflow_seen;
    t_verdict         pending_verdicts [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_left    = 0;

    int items_sent       = 0;
    int verdicts_checked = 0;
    int hits_seen        = 0;
    int overflows_seen   = 0;
    int error_count      = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [7:0] to_upper(logic [7:0] c);
        if ((c >= 8'h61 && c <= 8'h7A) || c >= 8'hE0) begin
            return c - 8'h20;
        end
        if (c == 8'hB8) begin
            return 8'hA8;
        end
        return c;
    endfunction

    // Let an active star also activate the position after it; ascending order
    // carries the closure through runs of stars.
    function automatic logic [ACT_W-1:0] close_stars(logic [ACT_W-1:0] v);
        for (int i = 0; i < mask_len; i++) begin
            if (v[i] && mask_bytes[i] == SYM_STAR) begin
                v[i+1] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [ACT_W-1:0] start_closure();
        return close_stars({{(ACT_W-1){1'b0}}, 1'b1});
    endfunction

    function automatic void apply_request(t_op op, logic [7:0] raw);
        logic [7:0]       b;
        logic [ACT_W-1:0] nxt;
        t_verdict         v;
        b = to_upper(raw);
        case (op)
            OP_MASK_BYTE: begin
                if (mask_len < MASK_MAX) begin
                    mask_bytes[mask_len] = b;
                    mask_len++;
                end else begin
                    overflow_seen = 1'b1;
                end
                live_pos = start_closure();
            end
            OP_TEXT_BYTE: begin
                nxt = '0;
                for (int i = 0; i < mask_len; i++) begin
                    if (live_pos[i]) begin
                        if (mask_bytes[i] == SYM_STAR) begin
                            nxt[i] = 1'b1;
                        end else if (mask_bytes[i] == SYM_ANY || mask_bytes[i] == b) begin
                            nxt[i+1] = 1'b1;
                        end
                    end
                end
                live_pos = close_stars(nxt);
            end
            OP_END_TEXT: begin
                v.matched       = (mask_len == 0) ? 1'b1 : live_pos[mask_len];
                v.mask_overflow = overflow_seen;
                pending_verdicts.push_back(v);
                live_pos = start_closure();
            end
            default: begin
                mask_len      = 0;
                overflow_seen = 1'b0;
                live_pos      = start_closure();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, receiver, checker, watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hold the receiver off while hold_left counts down, else stall at random.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic flag_mismatch(string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_verdict();
        t_verdict want;
        if (pending_verdicts.size() == 0) begin
            flag_mismatch("result with no end-of-text request pending");
            return;
        end
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (want.matched) hits_seen++;
        if (want.mask_overflow) overflows_seen++;
        if (rsp_ch.matched !== want.matched) begin
            flag_mismatch($sformatf("result %0d: matched %b, expected %b",
                                    verdicts_checked, rsp_ch.matched, want.matched));
        end
        if (rsp_ch.mask_overflow !== want.mask_overflow) begin
            flag_mismatch($sformatf("result %0d: mask_overflow %b, expected %b",
                                    verdicts_checked, rsp_ch.mask_overflow,
                                    want.mask_overflow));
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                check_verdict();
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("ERROR at %0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_verdicts.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_req(t_op op, logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid     = 1'b1;
        req_ch.operation = op;
        req_ch.data_byte = b;
        do @(posedge i_clk); while (!req_ch.ready);
        apply_request(op, b);
        items_sent++;
    endtask

    // Drop valid, then hold until every pending result has come back.
    task automatic wait_for_verdicts();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] filler_byte();
        if ($urandom_range(1)) begin
            return 8'h61 + 8'($urandom_range(3));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_mask_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25) return SYM_STAR;
        if (r < 40) return SYM_ANY;
        if (r < 78) return (8'h61 + 8'($urandom_range(3))) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
        if (r < 84) return $urandom_range(1) ? 8'hB8 : 8'hA8;
        return 8'($urandom_range(255));
    endfunction

    // Flip a folded mask byte back to a lower-case spelling half the time.
    function automatic logic [7:0] random_case(logic [7:0] m);
        if (!$urandom_range(1)) return m;
        if ((m >= 8'h41 && m <= 8'h5A) || (m >= 8'hC0 && m <= 8'hDF)) return m | 8'h20;
        if (m == 8'hA8) return 8'hB8;
        return m;
    endfunction

    // Build a text that fits the current mask, then break it now and then.
    task automatic build_text(ref logic [7:0] q[$]);
        int pos;
        q.delete();
        for (int i = 0; i < mask_len; i++) begin
            if (mask_bytes[i] == SYM_STAR) begin
                repeat ($urandom_range(3)) q.push_back(filler_byte());
            end else if (mask_bytes[i] == SYM_ANY) begin
                q.push_back(8'($urandom_range(255)));
            end else begin
                q.push_back(random_case(mask_bytes[i]));
            end
        end
        if (mask_len == 0) begin
            repeat ($urandom_range(4)) q.push_back(filler_byte());
        end
        if ($urandom_range(99) < 25 && q.size() > 0) begin
            pos = $urandom_range(q.size() - 1);
            case ($urandom_range(2))
                0: q.delete(pos);
                1: q.insert(pos, filler_byte());
                default: q[pos] = q[pos] ^ 8'h01;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_req(OP_CLEAR, 8'hFF);
        // empty mask with empty text, then with a text
        send_req(OP_END_TEXT, 8'h00);
        send_req(OP_TEXT_BYTE, 8'h00);
        send_req(OP_TEXT_BYTE, 8'hFF);
        send_req(OP_END_TEXT, 8'hFF);
        // case folding of the upper code page, star and any-byte
        send_req(OP_MASK_BYTE, 8'hB8);
        send_req(OP_MASK_BYTE, SYM_STAR);
        send_req(OP_MASK_BYTE, 8'hFF);
        send_req(OP_MASK_BYTE, SYM_ANY);
        send_req(OP_TEXT_BYTE, 8'hA8);
        send_req(OP_TEXT_BYTE, 8'h00);
        send_req(OP_TEXT_BYTE, 8'hDF);
        send_req(OP_TEXT_BYTE, 8'h7A);
        send_req(OP_END_TEXT, 8'h55);
        // empty text against a non-empty mask
        send_req(OP_END_TEXT, 8'hAA);
        // edit the mask in the middle of a text
        send_req(OP_TEXT_BYTE, 8'hA8);
        send_req(OP_MASK_BYTE, 8'h71);
        send_req(OP_TEXT_BYTE, 8'hB8);
        send_req(OP_END_TEXT, 8'h00);
        // last literal anchored at the end of the text
        send_req(OP_CLEAR, 8'h00);
        send_req(OP_MASK_BYTE, SYM_STAR);
        send_req(OP_MASK_BYTE, 8'h61);
        send_req(OP_TEXT_BYTE, 8'h61);
        send_req(OP_TEXT_BYTE, 8'h42);
        send_req(OP_TEXT_BYTE, 8'h41);
        send_req(OP_END_TEXT, 8'h00);
        wait_for_verdicts();
    endtask

    task automatic test_mask_full();
        src_idle_pct = 10;
        snk_idle_pct = 10;
        send_req(OP_CLEAR, 8'h00);
        repeat (MASK_MAX) send_req(OP_MASK_BYTE, SYM_STAR);
        send_req(OP_MASK_BYTE, 8'h78);
        send_req(OP_TEXT_BYTE, 8'h6B);
        send_req(OP_END_TEXT, 8'h00);
        send_req(OP_CLEAR, 8'h00);
        send_req(OP_END_TEXT, 8'h00);
        wait_for_verdicts();
    endtask

    // Hold the receiver off while results keep coming so the input stalls.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 20;
        send_req(OP_CLEAR, 8'h00);
        send_req(OP_MASK_BYTE, 8'h61);
        send_req(OP_MASK_BYTE, SYM_STAR);
        hold_left = 120;
        repeat (24) begin
            send_req(OP_TEXT_BYTE, $urandom_range(1) ? 8'h41 : 8'h62);
            send_req(OP_END_TEXT, 8'($urandom_range(255)));
        end
        wait_for_verdicts();
    endtask

    task automatic test_random_traffic(int src_pct, int snk_pct, int n_items);
        int         stop_at;
        int         n_mask;
        logic [7:0] text_q [$];
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at      = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 12) begin
                repeat ($urandom_range(1, 4)) begin
                    send_req(t_op'($urandom_range(3)), 8'($urandom_range(255)));
                end
            end else begin
                if ($urandom_range(99) < 75) send_req(OP_CLEAR, 8'($urandom_range(255)));
                n_mask = ($urandom_range(99) < 6) ? $urandom_range(28, 35) : $urandom_range(7);
                repeat (n_mask) send_req(OP_MASK_BYTE, pick_mask_byte());
                repeat ($urandom_range(1, 4)) begin
                    build_text(text_q);
                    foreach (text_q[i]) send_req(OP_TEXT_BYTE, text_q[i]);
                    send_req(OP_END_TEXT, 8'($urandom_range(255)));
                end
            end
        end
        wait_for_verdicts();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_MASK_BYTE;
        req_ch.data_byte = 8'h00;
        mask_len         = 0;
        overflow_seen    = 1'b0;
        live_pos         = start_closure();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_mask_full();
        test_backpressure();
        test_random_traffic(31, 52, RANDOM_ITEMS / 3);
        test_random_traffic(52, 31, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_for_verdicts();

        $display("Run covered %0d requests and %0d match results (%0d hits, %0d overflow)",
                 items_sent, verdicts_checked, hits_seen, overflows_seen);
        $display("Mask folding, stars, any-byte, full mask, edits mid-text and stalls done");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/wmm_pkg.sv
rtl/wmm_if.sv
rtl/wmm_front.sv
rtl/wmm_back.sv
rtl/wildcard_mask_matcher.sv
tb/testbench.sv
